// ----- rtl/core/chls_pkg.sv -----
package chls_pkg;

  localparam int QW         = 32;
  localparam int FRAC_W     = 16;
  localparam int NUM_W      = 48;
  localparam int ORDER_W    = 5;
  localparam int RHS_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic signed [QW-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATRIX_ORDER = 2'd0,
    CFG_RHS_COLUMNS  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                 kind;
    logic [3:0]           row_index;
    logic [3:0]           col_index;
    logic signed [QW-1:0] element_value;
    logic                 last_load;
  } in_item_t;

  typedef struct packed {
    logic [3:0]           out_row;
    logic [1:0]           out_col;
    logic signed [QW-1:0] solution_value;
    logic                 pivot_error;
    logic                 last_result;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ds_req_t;

endpackage

// ----- rtl/core/chls_mac.sv -----
module chls_mac import chls_pkg::*; #(
  parameter int ACC_W = 54
) (
  input  logic                    clk_i,
  input  logic                    clear_i,
  input  logic                    mul_en_i,
  input  logic                    add_en_i,
  input  logic signed [QW-1:0]    a_i,
  input  logic signed [QW-1:0]    b_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [2*QW-1:0] prod_q;
  logic signed [2*QW-1:0] prod_sh;
  logic signed [ACC_W-1:0] acc_q;

  // product floored to Q16.16
  assign prod_sh = prod_q >>> FRAC_W;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= a_i * b_i;
    end
    if (clear_i) begin
      acc_q <= '0;
    end else if (add_en_i) begin
      acc_q <= acc_q + ACC_W'(prod_sh);
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- rtl/core/chls_divsqrt.sv -----
module chls_divsqrt import chls_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ds_req_t              req_i,
  input  logic [NUM_W-1:0]     operand_i,
  input  logic [QW-1:0]        divisor_i,
  output logic                 done_o,
  output logic signed [QW-1:0] result_o
);

  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int ROOT_W = NUM_W / 2;

  typedef enum logic [1:0] {DS_IDLE, DS_RUN, DS_FIN} ds_state_e;

  ds_state_e            state_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 done_q;
  logic signed [QW-1:0] result_q;

  logic                 sqrt_q;
  logic                 neg_q;
  logic [QW-1:0]        den_q;
  logic [NUM_W-1:0]     work_q;
  logic [QW:0]          rem_q;
  logic [ROOT_W-1:0]    root_q;

  logic [QW:0]          div_sh;
  logic                 div_ge;
  logic [QW:0]          div_rem;
  logic [ROOT_W+2:0]    sq_sh;
  logic [ROOT_W+2:0]    sq_trial;
  logic                 sq_ge;
  logic [ROOT_W+2:0]    sq_rem;
  logic signed [QW-1:0] div_res;

  // restoring division, one quotient bit a cycle
  assign div_sh  = {rem_q[QW-1:0], work_q[NUM_W-1]};
  assign div_ge  = div_sh >= {1'b0, den_q};
  assign div_rem = div_ge ? div_sh - {1'b0, den_q} : div_sh;

  // digit-by-digit square root, two radicand bits a cycle
  assign sq_sh    = {rem_q[ROOT_W:0], work_q[NUM_W-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_rem   = sq_ge ? sq_sh - sq_trial : sq_sh;

  always_comb begin
    if (!neg_q) begin
      div_res = (work_q > NUM_W'(Q_MAX)) ? Q_MAX : QW'(work_q);
    end else begin
      div_res = (work_q > {{(NUM_W-QW){1'b0}}, 1'b1, {(QW-1){1'b0}}}) ?
                Q_MIN : QW'(~work_q[QW-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= DS_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        DS_IDLE: begin
          if (req_i.start) begin
            cnt_q   <= req_i.is_sqrt ? CNT_W'(ROOT_W) : CNT_W'(NUM_W);
            state_q <= DS_RUN;
          end
        end
        DS_RUN: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_q <= DS_FIN;
          end
        end
        DS_FIN: begin
          result_q <= sqrt_q ? QW'(root_q) : div_res;
          done_q   <= 1'b1;
          state_q  <= DS_IDLE;
        end
        default: state_q <= DS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DS_IDLE && req_i.start) begin
      sqrt_q <= req_i.is_sqrt;
      neg_q  <= !req_i.is_sqrt && operand_i[NUM_W-1];
      den_q  <= divisor_i;
      rem_q  <= '0;
      root_q <= '0;
      if (!req_i.is_sqrt && operand_i[NUM_W-1]) begin
        work_q <= ~operand_i + 1'b1;
      end else begin
        work_q <= operand_i;
      end
    end else if (state_q == DS_RUN) begin
      if (sqrt_q) begin
        rem_q  <= (QW+1)'(sq_rem);
        root_q <= {root_q[ROOT_W-2:0], sq_ge};
        work_q <= {work_q[NUM_W-3:0], 2'b00};
      end else begin
        rem_q  <= div_rem;
        work_q <= {work_q[NUM_W-2:0], div_ge};
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- rtl/core/cholesky_linear_solve_unit.sv -----
// a solve of order n with m columns uses one shared bit-serial divider/root unit for
// every divided entry of L, y and x and every diagonal root, and one shared multiply-accumulate
// unit for the inner-sum terms; each result is emitted through the ORD and OEMIT states
// loading takes one item a cycle while busy is low; busy stays high from the last load to the last result
// results are strobed for one cycle each and cannot be stalled by the receiver
// reset is asynchronous: order and column registers return to 1, error flag clears, stores hold garbage
module cholesky_linear_solve_unit import chls_pkg::*; #(
  parameter int MAX_ORDER = 16,
  parameter int MAX_RHS   = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  output out_item_t             out_o
);

  localparam int IW    = $clog2(MAX_ORDER + 1);
  localparam int MW    = $clog2(MAX_RHS + 1);
  localparam int JW    = (IW > MW) ? IW : MW;
  localparam int LD    = MAX_ORDER * MAX_ORDER;
  localparam int VD    = MAX_ORDER * MAX_RHS;
  localparam int LAW   = (LD > 1) ? $clog2(LD) : 1;
  localparam int VAW   = (VD > 1) ? $clog2(VD) : 1;
  localparam int ACC_W = 2 * QW - FRAC_W + IW + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_RD, ST_MUL, ST_ADD, ST_BASE, ST_DIFF, ST_WAIT, ST_ORD, ST_OEMIT
  } state_e;

  typedef enum logic [1:0] {PH_FACT, PH_FWD, PH_BACK} phase_e;

  function automatic logic [LAW-1:0] l_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return LAW'(LAW'(r) * LAW'(MAX_ORDER) + LAW'(c));
  endfunction

  function automatic logic [VAW-1:0] v_addr(input logic [IW-1:0] r, input logic [JW-1:0] c);
    return VAW'(VAW'(r) * VAW'(MAX_RHS) + VAW'(c));
  endfunction

  state_e                state_q;
  phase_e                phase_q;
  logic [IW-1:0]         i_q, k_q, kend_q, n_q;
  logic [JW-1:0]         j_q;
  logic [MW-1:0]         m_q;
  logic                  err_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic [ORDER_W-1:0]    order_q;
  logic [RHS_W-1:0]      rhs_q;

  logic signed [QW-1:0]  a_mem [LD];
  logic signed [QW-1:0]  b_mem [VD];
  logic signed [QW-1:0]  l_mem [LD];
  logic signed [QW-1:0]  v_mem [VD];
  logic signed [QW-1:0]  a_rd_q, b_rd_q, la_rd_q, lb_rd_q, v_rd_q;

  logic                  load_en, a_we, b_we, l_we, v_we;
  logic [LAW-1:0]        a_waddr, a_raddr, la_addr, lb_addr, l_waddr;
  logic [VAW-1:0]        b_waddr, b_raddr, v_raddr, v_waddr;

  logic signed [ACC_W-1:0] acc;
  logic signed [QW-1:0]  mac_b;
  logic signed [QW-1:0]  base;
  logic signed [ACC_W:0] diff;
  logic signed [QW-1:0]  diff_sat;
  logic                  is_diag, pivot_bad;
  ds_req_t               ds_req;
  logic                  ds_done;
  logic signed [QW-1:0]  ds_result;

  logic [IW-1:0]         n_sat, kstart, kend;
  logic [MW-1:0]         m_sat;
  logic                  i_last, j_last;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_W'(1);
      rhs_q   <= RHS_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MATRIX_ORDER: order_q <= cfg_data_i[ORDER_W-1:0];
        CFG_RHS_COLUMNS:  rhs_q   <= cfg_data_i[RHS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (order_q == '0) begin
      n_sat = IW'(1);
    end else if (int'(order_q) > MAX_ORDER) begin
      n_sat = IW'(MAX_ORDER);
    end else begin
      n_sat = IW'(order_q);
    end
    if (rhs_q == '0) begin
      m_sat = MW'(1);
    end else if (int'(rhs_q) > MAX_RHS) begin
      m_sat = MW'(MAX_RHS);
    end else begin
      m_sat = MW'(rhs_q);
    end
  end

  // load transfers
  assign busy    = state_q != ST_IDLE;
  assign load_en = start && !busy;
  assign a_we    = load_en && !in_i.kind && int'(in_i.row_index) < MAX_ORDER &&
                   int'(in_i.col_index) < MAX_ORDER;
  assign b_we    = load_en && in_i.kind && int'(in_i.row_index) < MAX_ORDER &&
                   int'(in_i.col_index) < MAX_RHS;
  assign a_waddr = LAW'(LAW'(in_i.row_index) * LAW'(MAX_ORDER) + LAW'(in_i.col_index));
  assign b_waddr = VAW'(VAW'(in_i.row_index) * VAW'(MAX_RHS) + VAW'(in_i.col_index));

  // read addresses
  assign a_raddr = l_addr(i_q, IW'(j_q));
  assign b_raddr = v_addr(i_q, j_q);
  assign la_addr = (phase_q == PH_BACK) ? l_addr(k_q, i_q) : l_addr(i_q, k_q);

  always_comb begin
    if (state_q == ST_RD) begin
      lb_addr = l_addr(IW'(j_q), k_q);
      v_raddr = v_addr(k_q, j_q);
    end else begin
      lb_addr = (phase_q == PH_FACT) ? l_addr(IW'(j_q), IW'(j_q)) : l_addr(i_q, i_q);
      v_raddr = v_addr(i_q, j_q);
    end
  end

  assign l_waddr = l_addr(i_q, IW'(j_q));
  assign v_waddr = v_addr(i_q, j_q);
  assign l_we    = state_q == ST_WAIT && ds_done && phase_q == PH_FACT;
  assign v_we    = state_q == ST_WAIT && ds_done && phase_q != PH_FACT;

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_waddr] <= in_i.element_value;
    end
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[b_waddr] <= in_i.element_value;
    end
    b_rd_q <= b_mem[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      l_mem[l_waddr] <= ds_result;
    end
    la_rd_q <= l_mem[la_addr];
    lb_rd_q <= l_mem[lb_addr];
  end

  // y is overwritten in place by x during back substitution
  always_ff @(posedge clk_i) begin
    if (v_we) begin
      v_mem[v_waddr] <= ds_result;
    end
    v_rd_q <= v_mem[v_raddr];
  end

  // shared multiply-accumulate
  assign mac_b = (phase_q == PH_FACT) ? lb_rd_q : v_rd_q;

  chls_mac #(.ACC_W(ACC_W)) u_mac (
    .clk_i    (clk_i),
    .clear_i  (state_q == ST_INIT),
    .mul_en_i (state_q == ST_MUL),
    .add_en_i (state_q == ST_ADD),
    .a_i      (la_rd_q),
    .b_i      (mac_b),
    .acc_o    (acc)
  );

  // element minus sum, saturated
  always_comb begin
    unique case (phase_q)
      PH_FACT: base = a_rd_q;
      PH_FWD:  base = b_rd_q;
      default: base = v_rd_q;
    endcase
    diff = {{(ACC_W+1-QW){base[QW-1]}}, base} - {acc[ACC_W-1], acc};
    if (diff > $signed({{(ACC_W+1-QW){1'b0}}, Q_MAX})) begin
      diff_sat = Q_MAX;
    end else if (diff < $signed({{(ACC_W+1-QW){1'b1}}, Q_MIN})) begin
      diff_sat = Q_MIN;
    end else begin
      diff_sat = QW'(diff);
    end
  end

  assign is_diag        = phase_q == PH_FACT && i_q == IW'(j_q);
  assign pivot_bad      = is_diag && (diff_sat[QW-1] || diff_sat == '0);
  assign ds_req.start   = state_q == ST_DIFF && !pivot_bad;
  assign ds_req.is_sqrt = is_diag;

  chls_divsqrt u_divsqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ds_req),
    .operand_i ({diff_sat, {FRAC_W{1'b0}}}),
    .divisor_i (lb_rd_q),
    .done_o    (ds_done),
    .result_o  (ds_result)
  );

  // inner-sum range for the current element
  always_comb begin
    unique case (phase_q)
      PH_FACT: begin
        kstart = '0;
        kend   = IW'(j_q);
      end
      PH_FWD: begin
        kstart = '0;
        kend   = i_q;
      end
      default: begin
        kstart = i_q + 1'b1;
        kend   = n_q;
      end
    endcase
  end

  assign i_last = (i_q + 1'b1) == n_q;
  assign j_last = JW'(j_q + 1'b1) == JW'(m_q);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FACT;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      kend_q      <= '0;
      n_q         <= IW'(1);
      m_q         <= MW'(1);
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start && in_i.last_load) begin
            n_q     <= n_sat;
            m_q     <= m_sat;
            err_q   <= 1'b0;
            phase_q <= PH_FACT;
            i_q     <= '0;
            j_q     <= '0;
            state_q <= ST_INIT;
          end
        end
        ST_INIT: begin
          k_q     <= kstart;
          kend_q  <= kend;
          state_q <= (kstart == kend) ? ST_BASE : ST_RD;
        end
        ST_RD:  state_q <= ST_MUL;
        ST_MUL: state_q <= ST_ADD;
        ST_ADD: begin
          k_q     <= k_q + 1'b1;
          state_q <= ((k_q + 1'b1) == kend_q) ? ST_BASE : ST_RD;
        end
        ST_BASE: state_q <= ST_DIFF;
        ST_DIFF: begin
          if (pivot_bad) begin
            err_q   <= 1'b1;
            i_q     <= '0;
            j_q     <= '0;
            state_q <= ST_ORD;
          end else begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (ds_done) begin
            state_q <= ST_INIT;
            unique case (phase_q)
              PH_FACT: begin
                if (is_diag) begin
                  j_q <= '0;
                  if (i_last) begin
                    phase_q <= PH_FWD;
                    i_q     <= '0;
                  end else begin
                    i_q <= i_q + 1'b1;
                  end
                end else begin
                  j_q <= j_q + 1'b1;
                end
              end
              PH_FWD: begin
                if (j_last) begin
                  j_q <= '0;
                  if (i_last) begin
                    phase_q <= PH_BACK;
                    i_q     <= n_q - 1'b1;
                  end else begin
                    i_q <= i_q + 1'b1;
                  end
                end else begin
                  j_q <= j_q + 1'b1;
                end
              end
              default: begin
                if (j_last) begin
                  j_q <= '0;
                  if (i_q == '0) begin
                    state_q <= ST_ORD;
                  end else begin
                    i_q <= i_q - 1'b1;
                  end
                end else begin
                  j_q <= j_q + 1'b1;
                end
              end
            endcase
          end
        end
        ST_ORD: state_q <= ST_OEMIT;
        ST_OEMIT: begin
          out_valid_q          <= 1'b1;
          out_q.out_row        <= 4'(i_q);
          out_q.out_col        <= 2'(j_q);
          out_q.solution_value <= err_q ? '0 : v_rd_q;
          out_q.pivot_error    <= err_q;
          out_q.last_result    <= i_last && j_last;
          if (i_last && j_last) begin
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_ORD;
            if (j_last) begin
              j_q <= '0;
              i_q <= i_q + 1'b1;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(state_q == ST_OEMIT))
    else $error("result strobe without an emit cycle");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.pivot_error) |-> out_o.solution_value == '0)
    else $error("non-zero result after pivot error");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ds_done |-> state_q == ST_WAIT)
    else $error("divider finished outside wait state");

  a_start_only_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ds_req.start |=> state_q == ST_WAIT)
    else $error("divider started without waiting");

endmodule
